// ===== sv/bmia_pkg.sv =====
// bmia_pkg: shared types, widths, codes and defaults for the block-mapped item allocator.
// No dependencies. Used by every module of the block.
package bmia_pkg;

  localparam int MAX_SLOTS_DEF     = 256;
  localparam int POOL_BLOCKS_DEF   = 4096;
  localparam int MAX_PER_BLOCK_DEF = 256;

  localparam int ITEM_SPACE = 65536;

  localparam int ITEM_W      = 16;
  localparam int TOTAL_W     = 17;
  localparam int FIRST_W     = 18;
  localparam int OFF_W       = 24;
  localparam int IB_W        = 13;
  localparam int IPB_W       = 9;
  localparam int BB_W        = 13;
  localparam int PL_W        = 13;
  localparam int SL_W        = 9;
  localparam int RUN_W       = 9;
  localparam int STATUS_W    = 3;
  localparam int BT_W        = 13;
  localparam int MUL_X_W     = 16;
  localparam int MUL_P_W     = MUL_X_W + IB_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = ITEM_W + OFF_W + 1 + TOTAL_W + BT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int DIV_STEPS   = TOTAL_W;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RESERVE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_UNMAPPED    = 3'd1,
    ST_SLOT_LIMIT  = 3'd2,
    ST_POOL_EMPTY  = 3'd3,
    ST_RUN_LONG    = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ITEM_BYTES    = 3'd0,
    CFG_ITEMS_IN_BLK  = 3'd1,
    CFG_BLOCK_BYTES   = 3'd2,
    CFG_POOL_LIMIT    = 3'd3,
    CFG_SECTION_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_LOOK,
    S_STEP,
    S_MULA,
    S_MULB,
    S_ADD,
    S_FIN
  } state_t;

  // Configuration as the datapath uses it; ipb, plim and slim are clamped, ib and bb are not.
  typedef struct packed {
    logic [IB_W-1:0]  ib;
    logic [IPB_W-1:0] ipb;
    logic [BB_W-1:0]  bb;
    logic [PL_W-1:0]  plim;
    logic [SL_W-1:0]  slim;
  } cfg_t;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    div_step;
    logic    check;
    logic    rd;
    logic    look;
    logic    claim;
    logic    skip_slot;
    logic    set_status;
    status_t status_code;
    logic    mul_a;
    logic    mul_b;
    logic    add;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    op_t  op;
    logic create;
    logic total_full;
    logic slot_oob;
    logic next_oob;
    logic skip;
    logic run_long;
    logic span_over;
    logic rd_valid;
    logic slot_lim;
    logic pool_empty;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/block_mapped_item_allocator_top.sv =====
// block_mapped_item_allocator_top: top level of the block-mapped item allocator.
// Depends on bmia_pkg, bmia_cfg, bmia_ctrl and bmia_dp.
//
// Maps item numbers of one section onto fixed-size blocks taken on demand from a
// shared pool; append, lookup (optionally creating) and reserve-run requests each
// return one result. After reset the slot map is cleared one entry per cycle, so
// in_tready stays low until the clear pass ends (configuration writes are taken all the
// while). One request is processed at a time: a bit-serial divide by items-per-block,
// one or two slot-map memory reads (a reserve that skips to the next block reads twice),
// and the shared offset multiplier and add; a failed request skips the steps after its
// failing check. The result sits in an output register, so a new request is taken while
// the previous result waits.
module block_mapped_item_allocator_top #(
  parameter int MAX_SLOTS     = bmia_pkg::MAX_SLOTS_DEF,
  parameter int POOL_BLOCKS   = bmia_pkg::POOL_BLOCKS_DEF,
  parameter int MAX_PER_BLOCK = bmia_pkg::MAX_PER_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] item_number, [16] create_flag, [25:17] run_length
  input  logic [bmia_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  logic [bmia_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] item_id, [39:16] byte_offset, [40] fresh_block, [57:41] items_held,
  // [70:58] blocks_taken
  output logic [bmia_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [2:0] status
  output logic [bmia_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmia_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bmia_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bmia_pkg::cfg_t    cfg;
  bmia_pkg::dp_cmd_t cmd;
  bmia_pkg::dp_sts_t sts;

  bmia_cfg #(
    .MAX_SLOTS     (MAX_SLOTS),
    .POOL_BLOCKS   (POOL_BLOCKS),
    .MAX_PER_BLOCK (MAX_PER_BLOCK)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmia_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/bmia_cfg.sv =====
// bmia_cfg: configuration registers and their working values (ipb, plim and slim clamped).
// Depends on bmia_pkg.
module bmia_cfg #(
  parameter int MAX_SLOTS     = bmia_pkg::MAX_SLOTS_DEF,
  parameter int POOL_BLOCKS   = bmia_pkg::POOL_BLOCKS_DEF,
  parameter int MAX_PER_BLOCK = bmia_pkg::MAX_PER_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmia_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bmia_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bmia_pkg::cfg_t                    cfg
);

  logic [bmia_pkg::IB_W-1:0]  item_bytes_r;
  logic [bmia_pkg::IPB_W-1:0] items_in_blk_r;
  logic [bmia_pkg::BB_W-1:0]  block_bytes_r;
  logic [bmia_pkg::PL_W-1:0]  pool_limit_r;
  logic [bmia_pkg::SL_W-1:0]  section_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_bytes_r    <= bmia_pkg::IB_W'(1);
      items_in_blk_r  <= bmia_pkg::IPB_W'(1);
      block_bytes_r   <= bmia_pkg::BB_W'(4096);
      pool_limit_r    <= bmia_pkg::PL_W'(4096);
      section_limit_r <= bmia_pkg::SL_W'(256);
    end else if (cfg_valid) begin
      unique case (bmia_pkg::cfg_reg_t'(cfg_addr))
        bmia_pkg::CFG_ITEM_BYTES:    item_bytes_r    <= cfg_data[bmia_pkg::IB_W-1:0];
        bmia_pkg::CFG_ITEMS_IN_BLK:  items_in_blk_r  <= cfg_data[bmia_pkg::IPB_W-1:0];
        bmia_pkg::CFG_BLOCK_BYTES:   block_bytes_r   <= cfg_data[bmia_pkg::BB_W-1:0];
        bmia_pkg::CFG_POOL_LIMIT:    pool_limit_r    <= cfg_data[bmia_pkg::PL_W-1:0];
        bmia_pkg::CFG_SECTION_LIMIT: section_limit_r <= cfg_data[bmia_pkg::SL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.ib = item_bytes_r;
    cfg.bb = block_bytes_r;
    if (items_in_blk_r == '0) begin
      cfg.ipb = bmia_pkg::IPB_W'(1);
    end else if (32'(items_in_blk_r) > MAX_PER_BLOCK) begin
      cfg.ipb = bmia_pkg::IPB_W'(MAX_PER_BLOCK);
    end else begin
      cfg.ipb = items_in_blk_r;
    end
    if (32'(pool_limit_r) > POOL_BLOCKS) begin
      cfg.plim = bmia_pkg::PL_W'(POOL_BLOCKS);
    end else begin
      cfg.plim = pool_limit_r;
    end
    if (32'(section_limit_r) > MAX_SLOTS) begin
      cfg.slim = bmia_pkg::SL_W'(MAX_SLOTS);
    end else begin
      cfg.slim = section_limit_r;
    end
  end

endmodule

// ===== sv/bmia_ctrl.sv =====
// bmia_ctrl: request sequencer; issues datapath commands and picks the status code.
// Depends on bmia_pkg.
module bmia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bmia_pkg::dp_sts_t sts,
  output bmia_pkg::dp_cmd_t cmd
);

  bmia_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmia_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic go_on;
    go_on     = 1'b0;
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      bmia_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = bmia_pkg::S_IDLE;
      end
      bmia_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = bmia_pkg::S_DIV;
        end
      end
      bmia_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = bmia_pkg::S_CHECK;
      end
      bmia_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = bmia_pkg::S_FIN;
        unique case (sts.op)
          bmia_pkg::OP_APPEND: begin
            if (sts.total_full || sts.slot_oob) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bmia_pkg::ST_SLOT_LIMIT;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = bmia_pkg::S_LOOK;
            end
          end
          bmia_pkg::OP_LOOKUP: begin
            if (sts.slot_oob) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = sts.create ? bmia_pkg::ST_SLOT_LIMIT : bmia_pkg::ST_UNMAPPED;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = bmia_pkg::S_LOOK;
            end
          end
          bmia_pkg::OP_RESERVE: begin
            if (sts.run_long) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bmia_pkg::ST_RUN_LONG;
            end else if (sts.span_over || sts.slot_oob || (sts.skip && sts.next_oob)) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = bmia_pkg::ST_SLOT_LIMIT;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = bmia_pkg::S_LOOK;
            end
          end
          default: ;
        endcase
      end
      bmia_pkg::S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = bmia_pkg::S_FIN;
        if (sts.rd_valid) begin
          go_on = 1'b1;
        end else if (sts.op == bmia_pkg::OP_LOOKUP && !sts.create) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bmia_pkg::ST_UNMAPPED;
        end else if (sts.slot_lim) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bmia_pkg::ST_SLOT_LIMIT;
        end else if (sts.pool_empty) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = bmia_pkg::ST_POOL_EMPTY;
        end else begin
          cmd.claim = 1'b1;
          go_on     = 1'b1;
        end
        if (go_on) begin
          if (sts.op == bmia_pkg::OP_RESERVE && sts.skip) begin
            cmd.skip_slot = 1'b1;
            state_nxt     = bmia_pkg::S_STEP;
          end else begin
            state_nxt = bmia_pkg::S_MULA;
          end
        end
      end
      bmia_pkg::S_STEP: begin
        cmd.rd    = 1'b1;
        state_nxt = bmia_pkg::S_LOOK;
      end
      bmia_pkg::S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = bmia_pkg::S_MULB;
      end
      bmia_pkg::S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = bmia_pkg::S_ADD;
      end
      bmia_pkg::S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = bmia_pkg::S_FIN;
      end
      bmia_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = bmia_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmia_pkg::S_CLEAR;
    endcase
  end

endmodule

// ===== sv/bmia_dp.sv =====
// bmia_dp: request registers, serial divider, slot map memory, offset multiplier,
// counters and the result register. Depends on bmia_pkg.
module bmia_dp #(
  parameter int MAX_SLOTS   = bmia_pkg::MAX_SLOTS_DEF,
  parameter int POOL_BLOCKS = bmia_pkg::POOL_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [bmia_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [bmia_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  bmia_pkg::cfg_t                     cfg,
  input  bmia_pkg::dp_cmd_t                  cmd,
  output bmia_pkg::dp_sts_t                  sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bmia_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [bmia_pkg::STATUS_W-1:0]      out_tuser
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int BLK_W  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int PU_W   = $clog2(POOL_BLOCKS + 1);
  localparam int ENT_W  = BLK_W + 1;
  localparam int DIVC_W = $clog2(bmia_pkg::DIV_STEPS);
  localparam int PAD_W  = bmia_pkg::OUT_TDATA_W - bmia_pkg::OUT_FIELD_W;

  // request
  bmia_pkg::op_t                  op_r;
  logic [bmia_pkg::ITEM_W-1:0]    item_r;
  logic                           create_r;
  logic [bmia_pkg::RUN_W-1:0]     run_r;
  // divider: slot_r holds the quotient, pos_r the remainder
  logic [DIVC_W-1:0]              div_cnt_r;
  logic [bmia_pkg::TOTAL_W-1:0]   slot_r;
  logic [bmia_pkg::IPB_W-1:0]     pos_r;
  logic [bmia_pkg::FIRST_W-1:0]   first_r;
  bmia_pkg::status_t              status_r;
  logic [ENT_W-1:0]               rd_data_r;
  logic [BLK_W-1:0]               mapped_r;
  logic                           fresh_r;
  logic [bmia_pkg::OFF_W-1:0]     prod_r;
  logic [bmia_pkg::OFF_W-1:0]     off_r;
  // section state
  logic [bmia_pkg::TOTAL_W-1:0]   total_r;
  logic [PU_W-1:0]                pool_used_r;
  logic [SLOT_W-1:0]              clr_cnt_r;
  // result
  logic                           out_tvalid_r;
  logic [bmia_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [bmia_pkg::STATUS_W-1:0]  out_tuser_r;

  logic [ENT_W-1:0] slot_mem [MAX_SLOTS];

  logic [SLOT_W-1:0]              slot_idx;
  logic [bmia_pkg::TOTAL_W-1:0]   dividend;
  logic [bmia_pkg::IPB_W:0]       trial;
  logic                           trial_ge;
  logic [bmia_pkg::FIRST_W-1:0]   first_w;
  logic [bmia_pkg::MUL_X_W-1:0]   mul_x;
  logic [bmia_pkg::IB_W-1:0]      mul_y;
  logic [bmia_pkg::MUL_P_W-1:0]   mul_p;
  logic                           ok;
  logic [bmia_pkg::TOTAL_W-1:0]   total_nxt;
  logic [bmia_pkg::ITEM_W-1:0]    id_w;

  assign slot_idx = slot_r[SLOT_W-1:0];
  assign dividend = (bmia_pkg::op_t'(in_tuser) == bmia_pkg::OP_LOOKUP) ?
                    bmia_pkg::TOTAL_W'(in_tdata[bmia_pkg::ITEM_W-1:0]) : total_r;
  assign trial    = {pos_r, slot_r[bmia_pkg::TOTAL_W-1]};
  assign trial_ge = trial >= {1'b0, cfg.ipb};

  always_comb begin
    sts.skip = ({1'b0, pos_r} + {1'b0, run_r}) > {1'b0, cfg.ipb};
    if (sts.skip) begin
      first_w = bmia_pkg::FIRST_W'(total_r) + bmia_pkg::FIRST_W'(cfg.ipb)
              - bmia_pkg::FIRST_W'(pos_r);
    end else begin
      first_w = bmia_pkg::FIRST_W'(total_r);
    end
    sts.clr_done   = 32'(clr_cnt_r) == MAX_SLOTS - 1;
    sts.div_done   = div_cnt_r == DIVC_W'(bmia_pkg::DIV_STEPS - 1);
    sts.op         = op_r;
    sts.create     = create_r;
    sts.total_full = total_r[bmia_pkg::TOTAL_W-1];
    sts.slot_oob   = 32'(slot_r) >= MAX_SLOTS;
    sts.next_oob   = 32'(slot_r) + 1 >= MAX_SLOTS;
    sts.run_long   = run_r > cfg.ipb;
    sts.span_over  = (32'(first_w) + 32'(run_r)) > bmia_pkg::ITEM_SPACE;
    sts.rd_valid   = rd_data_r[BLK_W];
    sts.slot_lim   = slot_r >= bmia_pkg::TOTAL_W'(cfg.slim);
    sts.pool_empty = 32'(pool_used_r) >= 32'(cfg.plim);
    sts.out_free   = !out_tvalid_r || out_tready;
  end

  // one shared multiplier: block * block_bytes, then position * item_bytes
  always_comb begin
    mul_x = cmd.mul_a ? bmia_pkg::MUL_X_W'(mapped_r) : bmia_pkg::MUL_X_W'(pos_r);
    mul_y = cmd.mul_a ? cfg.bb : cfg.ib;
    mul_p = bmia_pkg::MUL_P_W'(mul_x) * bmia_pkg::MUL_P_W'(mul_y);
  end

  always_comb begin
    ok = status_r == bmia_pkg::ST_OK;
    total_nxt = total_r;
    if (ok && op_r == bmia_pkg::OP_APPEND) begin
      total_nxt = total_r + 1'b1;
    end else if (ok && op_r == bmia_pkg::OP_RESERVE) begin
      total_nxt = bmia_pkg::TOTAL_W'(first_r + bmia_pkg::FIRST_W'(run_r));
    end
    case (op_r)
      bmia_pkg::OP_LOOKUP:  id_w = item_r;
      bmia_pkg::OP_RESERVE: id_w = ok ? first_r[bmia_pkg::ITEM_W-1:0]
                                      : total_r[bmia_pkg::ITEM_W-1:0];
      bmia_pkg::OP_APPEND:  id_w = total_r[bmia_pkg::ITEM_W-1:0];
      default:              id_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      slot_mem[clr_cnt_r] <= '0;
    end else if (cmd.claim) begin
      slot_mem[slot_idx] <= {1'b1, BLK_W'(pool_used_r)};
    end
    if (cmd.rd) rd_data_r <= slot_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      pool_used_r  <= '0;
      clr_cnt_r    <= '0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.load) div_cnt_r <= '0;
      if (cmd.div_step) div_cnt_r <= div_cnt_r + 1'b1;
      if (cmd.claim) pool_used_r <= pool_used_r + 1'b1;
      if (cmd.finish) begin
        total_r      <= total_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= bmia_pkg::op_t'(in_tuser);
      item_r   <= in_tdata[bmia_pkg::ITEM_W-1:0];
      create_r <= in_tdata[bmia_pkg::ITEM_W];
      run_r    <= in_tdata[bmia_pkg::ITEM_W+bmia_pkg::RUN_W:bmia_pkg::ITEM_W+1];
      slot_r   <= dividend;
      pos_r    <= '0;
      status_r <= bmia_pkg::ST_OK;
      fresh_r  <= 1'b0;
      off_r    <= '0;
    end
    if (cmd.div_step) begin
      pos_r  <= trial_ge ? bmia_pkg::IPB_W'(trial - {1'b0, cfg.ipb})
                         : trial[bmia_pkg::IPB_W-1:0];
      slot_r <= {slot_r[bmia_pkg::TOTAL_W-2:0], trial_ge};
    end
    if (cmd.skip_slot) begin
      slot_r <= slot_r + 1'b1;
      pos_r  <= '0;
    end
    if (cmd.check) first_r <= first_w;
    if (cmd.set_status) status_r <= cmd.status_code;
    if (cmd.claim) begin
      mapped_r <= BLK_W'(pool_used_r);
      fresh_r  <= 1'b1;
    end else if (cmd.look) begin
      mapped_r <= rd_data_r[BLK_W-1:0];
    end
    if (cmd.mul_a || cmd.mul_b) prod_r <= mul_p[bmia_pkg::OFF_W-1:0];
    if (cmd.mul_b) off_r <= prod_r;
    if (cmd.add) off_r <= off_r + prod_r;
    if (cmd.finish) begin
      out_tuser_r <= status_r;
      out_tdata_r <= {{PAD_W{1'b0}}, bmia_pkg::BT_W'(pool_used_r), total_nxt,
                      fresh_r, off_r, id_w};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== sv/bmia_checker.sv =====
// bmia_checker: port-level assertions for the block-mapped item allocator, and its bind.
// Depends on bmia_pkg and block_mapped_item_allocator_top.
module bmia_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bmia_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [bmia_pkg::STATUS_W-1:0]     out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // failed requests carry no offset
  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bmia_pkg::ST_OK |-> out_tdata[39:16] == '0)
    else $error("nonzero byte offset on failed request");

  // one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // slot map clear pass and empty result register after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid right after reset");

endmodule

bind block_mapped_item_allocator_top bmia_checker u_bmia_checker (.*);
